[src/assert_macros.svh]
// Assertion macros shared by the TLB modules; they compile away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define TLBW_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define TLBW_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TLBW_ASSERT(name, clk, rst_n, prop, msg)
`define TLBW_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

[src/tlbw_pkg.sv]
// Types and constants shared by the TLB controller and datapath.
package tlbw_pkg;

    localparam logic [1:0] FUNC_XLATE = 2'd0;
    localparam logic [1:0] FUNC_RESP  = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    localparam logic [1:0] KIND_XLATE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;
    localparam logic [1:0] KIND_ACK   = 2'd3;

    localparam logic [1:0] WALK_IDLE = 2'd0;
    localparam logic [1:0] WALK_DIR  = 2'd1;
    localparam logic [1:0] WALK_TBL  = 2'd2;

    localparam logic [31:0] LCG_MUL    = 32'd25681;
    localparam logic [31:0] LCG_INC    = 32'd19546543;
    localparam logic [31:0] SEED_RESET = 32'd58236;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOOKUP,
        S_MOD,
        S_FILL
    } state_t;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_ACK,
        OUT_HIT,
        OUT_DIR_REQ,
        OUT_TBL_REQ,
        OUT_FAULT,
        OUT_FILL
    } out_sel_t;

    typedef enum logic [1:0] {
        W_HOLD,
        W_START,
        W_TABLE,
        W_END
    } walk_op_t;

    typedef struct packed {
        logic     capture;
        logic     probe;
        out_sel_t out_sel;
        walk_op_t walk_op;
        logic     flush;
        logic     seed_step;
        logic     mod_init;
        logic     mod_step;
        logic     install;
        logic     use_rem;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] stage;
        logic       hit;
        logic       present;
        logic       full;
    } status_t;

endpackage

[src/tlbw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tlbw_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/tlbw_dp.sv]
// TLB datapath: tag cells, frame RAM, walk registers, replacement seed and result register.
`include "assert_macros.svh"

module tlbw_dp import tlbw_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     st,
    input  logic [1:0]  func,
    input  logic [31:0] lin_addr,
    input  logic [31:0] read_data,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [1:0]  kind,
    output logic [31:0] out_addr
);

    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int RECIP_SH = 32 + IDX_W;
    // Ceiling reciprocal; the quotient is exact for every 32-bit seed since
    // ENTRIES is at most 2**IDX_W.
    localparam logic [32:0] RECIP =
        33'(((64'd1 << RECIP_SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));
    localparam logic [IDX_W-1:0] ENT_LOW = IDX_W'(ENTRIES);

    logic [31:0]        base_reg;
    logic [1:0]         func_reg;
    logic [31:0]        lin_reg;
    logic [31:0]        data_reg;
    logic [1:0]         stage_reg;
    logic [31:0]        walk_addr_reg;
    logic               hit_reg;
    logic [31:0]        seed_reg;
    logic [31:0]        lcg_next;
    logic [31:0]        mod_src_reg;
    logic [IDX_W-1:0]   mod_q_reg;
    logic [64:0]        recip_prod;
    logic [IDX_W-1:0]   rem_slot;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [19:0]        tag_reg [ENTRIES];
    logic [IDX_W-1:0]   match_idx;
    logic               match_any;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   slot;
    logic [19:0]        frame_rd;
    logic [31:0]        dir_addr;
    logic [1:0]         kind_c;
    logic [31:0]        addr_c;
    logic               done_reg;
    logic [1:0]         kind_reg;
    logic [31:0]        out_addr_reg;

    // Parallel tag compare; the lowest matching or free index wins.
    always_comb
    begin
        match_idx = '0;
        match_any = 1'b0;
        free_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (tag_reg[i] == lin_reg[31:12]))
            begin
                match_idx = IDX_W'(i);
                match_any = 1'b1;
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign slot = cmd.use_rem ? rem_slot : free_idx;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.flush)
        begin
            valid_next = '0;
        end
        else if (cmd.install)
        begin
            valid_next[slot] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.install)
        begin
            tag_reg[slot] <= walk_addr_reg[31:12];
        end
    end

    tlbw_ram #(
        .WIDTH (20),
        .DEPTH (ENTRIES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (cmd.install),
        .waddr (slot),
        .wdata (data_reg[31:12]),
        .raddr (match_idx),
        .rdata (frame_rd)
    );

    assign lcg_next   = seed_reg * LCG_MUL + LCG_INC;
    assign recip_prod = {33'd0, mod_src_reg} * {32'd0, RECIP};
    // The remainder is below 2**IDX_W, so only the low bits of seed - q*ENTRIES matter.
    assign rem_slot   = mod_src_reg[IDX_W-1:0] - mod_q_reg * ENT_LOW;

    assign dir_addr = base_reg + {20'd0, lin_reg[31:22], 2'b00};

    always_comb
    begin
        kind_c = KIND_ACK;
        addr_c = '0;
        case (cmd.out_sel)
            OUT_HIT:
            begin
                kind_c = KIND_XLATE;
                addr_c = {frame_rd, lin_reg[11:0]};
            end
            OUT_DIR_REQ:
            begin
                kind_c = KIND_READ;
                addr_c = dir_addr;
            end
            OUT_TBL_REQ:
            begin
                // The table index fills the low 12 bits exactly, so no carry arises.
                kind_c = KIND_READ;
                addr_c = {data_reg[31:12], walk_addr_reg[21:12], 2'b00};
            end
            OUT_FAULT:
            begin
                kind_c = KIND_FAULT;
                addr_c = '0;
            end
            OUT_FILL:
            begin
                kind_c = KIND_XLATE;
                addr_c = {data_reg[31:12], walk_addr_reg[11:0]};
            end
            default:
            begin
                kind_c = KIND_ACK;
                addr_c = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            stage_reg <= WALK_IDLE;
            hit_reg   <= 1'b0;
            seed_reg  <= SEED_RESET;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                base_reg <= cfg_data;
            end
            if (cmd.probe)
            begin
                hit_reg <= match_any;
            end
            if (cmd.seed_step)
            begin
                seed_reg <= lcg_next;
            end
            case (cmd.walk_op)
                W_START: stage_reg <= WALK_DIR;
                W_TABLE: stage_reg <= WALK_TBL;
                W_END:   stage_reg <= WALK_IDLE;
                default: stage_reg <= stage_reg;
            endcase
            valid_reg <= valid_next;
            done_reg  <= (cmd.out_sel != OUT_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            lin_reg  <= lin_addr;
            data_reg <= read_data;
        end
        if (cmd.walk_op == W_START)
        begin
            walk_addr_reg <= lin_reg;
        end
        if (cmd.mod_init)
        begin
            mod_src_reg <= lcg_next;
        end
        if (cmd.mod_step)
        begin
            mod_q_reg <= recip_prod[RECIP_SH +: IDX_W];
        end
        if (cmd.out_sel != OUT_NONE)
        begin
            kind_reg     <= kind_c;
            out_addr_reg <= addr_c;
        end
    end

    assign st.func    = func_reg;
    assign st.stage   = stage_reg;
    assign st.hit     = hit_reg;
    assign st.present = data_reg[0];
    assign st.full    = &valid_reg;

    assign done     = done_reg;
    assign kind     = kind_reg;
    assign out_addr = out_addr_reg;

    `TLBW_ASSERT(a_flush_clears, clk, rst_n,
        cmd.flush |=> (valid_reg == '0), "flush left a valid entry")
    `TLBW_NEVER(a_stage_code, clk, rst_n,
        stage_reg == 2'd3, "walk stage holds an unused code")
    `TLBW_ASSERT(a_free_slot, clk, rst_n,
        (cmd.install && !cmd.use_rem) |-> !valid_reg[free_idx],
        "fill without random replacement hit a valid slot")

endmodule

[src/tlbw_ctrl.sv]
// TLB controller: sequences lookup, page walk steps, replacement and result beats.
`include "assert_macros.svh"

module tlbw_ctrl import tlbw_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                if ((st.func == FUNC_XLATE) && (st.stage == WALK_IDLE))
                begin
                    state_next = S_LOOKUP;
                end
                else if ((st.func == FUNC_RESP) && (st.stage == WALK_TBL) && st.present
                         && st.full)
                begin
                    state_next = S_MOD;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_IDLE;
            end
            S_MOD:
            begin
                state_next = S_FILL;
            end
            S_FILL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '{capture: 1'b0, probe: 1'b0, out_sel: OUT_NONE, walk_op: W_HOLD,
                flush: 1'b0, seed_step: 1'b0, mod_init: 1'b0, mod_step: 1'b0,
                install: 1'b0, use_rem: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = start;
            end
            S_EXEC:
            begin
                unique case (st.func)
                    FUNC_XLATE:
                    begin
                        if (st.stage == WALK_IDLE)
                        begin
                            cmd.probe = 1'b1;
                        end
                        else
                        begin
                            cmd.out_sel = OUT_ACK;
                        end
                    end
                    FUNC_RESP:
                    begin
                        if (st.stage == WALK_DIR)
                        begin
                            cmd.out_sel = OUT_TBL_REQ;
                            cmd.walk_op = W_TABLE;
                        end
                        else if (st.stage == WALK_TBL)
                        begin
                            if (!st.present)
                            begin
                                cmd.out_sel = OUT_FAULT;
                                cmd.walk_op = W_END;
                            end
                            else if (!st.full)
                            begin
                                cmd.install = 1'b1;
                                cmd.out_sel = OUT_FILL;
                                cmd.walk_op = W_END;
                            end
                            else
                            begin
                                cmd.seed_step = 1'b1;
                                cmd.mod_init  = 1'b1;
                            end
                        end
                        else
                        begin
                            cmd.out_sel = OUT_ACK;
                        end
                    end
                    FUNC_FLUSH:
                    begin
                        cmd.flush   = 1'b1;
                        cmd.out_sel = OUT_ACK;
                    end
                    default:
                    begin
                        cmd.out_sel = OUT_ACK;
                    end
                endcase
            end
            S_LOOKUP:
            begin
                if (st.hit)
                begin
                    cmd.out_sel = OUT_HIT;
                end
                else
                begin
                    cmd.out_sel = OUT_DIR_REQ;
                    cmd.walk_op = W_START;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
            end
            S_FILL:
            begin
                cmd.install = 1'b1;
                cmd.use_rem = 1'b1;
                cmd.out_sel = OUT_FILL;
                cmd.walk_op = W_END;
            end
            default:
            begin
                cmd.out_sel = OUT_NONE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    `TLBW_ASSERT(a_beat_ends_item, clk, rst_n,
        (cmd.out_sel != OUT_NONE) |=> (state_reg == S_IDLE), "result beat did not end the item")
    `TLBW_ASSERT(a_fill_when_full, clk, rst_n,
        (state_reg == S_FILL) |-> st.full, "random replacement with a free slot")
    `TLBW_ASSERT(a_lookup_after_exec, clk, rst_n,
        (state_reg == S_LOOKUP) |-> ($past(state_reg) == S_EXEC), "lookup without a probe")

endmodule

[src/tlb_with_page_walk.sv]
// Top level of the fully associative TLB with a two-level page walk.
// An item is taken at a clock edge with start high and busy low; its single result
// beat shows on done, kind and out_addr for one cycle, in the cycle that busy falls,
// and cannot be held off. Flush, ignored items and walk steps end in the execute state,
// lookups in the lookup state (tag compare, then the frame RAM read). A fill into a
// full TLB ends in the fill state: the replacement seed is advanced, reduced modulo
// ENTRIES by a reciprocal multiply, and the entry is written. The page directory base
// register may be written at any time the block is idle; cfg_ready is always high.
module tlb_with_page_walk import tlbw_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] lin_addr,
    input  logic [31:0] read_data,
    output logic        done,
    output logic [1:0]  kind,
    output logic [31:0] out_addr,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    tlbw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .cmd   (cmd)
    );

    tlbw_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .func      (func),
        .lin_addr  (lin_addr),
        .read_data (read_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .done      (done),
        .kind      (kind),
        .out_addr  (out_addr)
    );

endmodule
